@@ rtl/mngq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mngq_pkg
// Shared types and constants for the MIDI note gate queue.
// ----------------------------------------------------------------------------
package mngq_pkg;

  localparam int NOTE_W = 7;
  localparam int VEL_W = 7;
  localparam int TIME_W = 32;
  localparam int GATE_W = 16;

  // A time check sends at most this many note-offs.
  localparam int MAX_MSGS = 8;
  localparam int MSG_CNT_W = $clog2(MAX_MSGS);

  localparam logic KIND_ON = 1'b0;
  localparam logic KIND_OFF = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_ZON    = 8'b0000_0010,
    S_ZOFF   = 8'b0000_0100,
    S_MATCH  = 8'b0000_1000,
    S_ON     = 8'b0001_0000,
    S_EVICT  = 8'b0010_0000,
    S_APPEND = 8'b0100_0000,
    S_EXPIRE = 8'b1000_0000
  } state_t;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic                remove;
    logic                at_head;
    logic [NOTE_W-1:0]   new_note;
    logic [TIME_W-1:0]   now;
    logic [GATE_W-1:0]   gate;
  } cell_ctl_t;

endpackage

@@ rtl/mngq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mngq_cell
// One entry of the playing-note list: holds a note and its start time.
// ----------------------------------------------------------------------------
module mngq_cell (
  input  logic                          clk,
  input  mngq_pkg::cell_ctl_t           ctl,
  input  logic                          live,
  input  logic                          head,
  input  logic                          load_here,
  input  logic                          shift_in,
  input  logic [mngq_pkg::NOTE_W-1:0]   nbr_note,
  input  logic [mngq_pkg::TIME_W-1:0]   nbr_start,
  output logic [mngq_pkg::NOTE_W-1:0]   note_q,
  output logic [mngq_pkg::TIME_W-1:0]   start_q,
  output logic                          expired,
  output logic                          shift_out
);

  logic                          match;
  logic                          pos;
  logic [mngq_pkg::TIME_W-1:0]   elapsed;

  assign match = live && (note_q == ctl.new_note);
  assign pos = ctl.at_head ? head : match;
  // Every entry behind the removed one moves one place toward the head.
  assign shift_out = shift_in | pos;

  assign elapsed = ctl.now - start_q;
  assign expired = (elapsed >= {{(mngq_pkg::TIME_W - mngq_pkg::GATE_W){1'b0}}, ctl.gate});

  always_ff @(posedge clk) begin
    if (ctl.remove && shift_out) begin
      note_q <= nbr_note;
      start_q <= nbr_start;
    end else if (load_here) begin
      note_q <= ctl.new_note;
      start_q <= ctl.now;
    end
  end

endmodule

@@ rtl/midi_note_gate_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_gate_queue
// Turns drum note hits into MIDI note-on / note-off words with a gate time.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid / in_ready) carries one word per hit or
// time check. command 0 is a note hit with note and velocity; command 1 asks
// for the note-offs of the notes whose gate time has run out at now_ms, at
// most MAX_MSGS per check. The output channel (out_valid / out_ready) carries
// MIDI message words; last marks the final word caused by one input word. A
// hit with an unassigned note, or a time check with nothing expired, produces
// no word at all. The gate time is written through cfg_wen / cfg_wdata; the
// user must write it only while idle, which the block itself does not enforce.
// Flow: the block handles one input word at a time. A hit first looks for
// its note in the list (that step also sends the note-off of a retriggered
// note), then sends the note-on, evicts the head when the list is full, and
// then appends the note; a hit with gate time 0 sends its note-on and
// note-off without using the list. A time check sends one note-off per step.
// With a ready receiver the first output word is registered in the cycle
// after the input is taken, except on a hit whose note is not already
// playing, where the match step comes first. The list is a chain of
// QUEUE_DEPTH cells; removal shifts all cells behind the removed entry
// toward the head together. Reset empties the list and clears the gate
// time to 0. If the receiver stalls, the output register holds its word and
// the sequencer waits.
module midi_note_gate_queue #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [7:0]                    note,
  input  logic [mngq_pkg::VEL_W-1:0]    velocity,
  input  logic [mngq_pkg::TIME_W-1:0]   now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          message_kind,
  output logic [mngq_pkg::NOTE_W-1:0]   out_note,
  output logic [mngq_pkg::VEL_W-1:0]    out_velocity,
  output logic                          last,
  input  logic                          cfg_wen,
  input  logic [mngq_pkg::GATE_W-1:0]   cfg_wdata
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  mngq_pkg::state_t                 state, state_next;
  logic [CW-1:0]                    cnt;
  logic [mngq_pkg::GATE_W-1:0]      gate;
  logic [mngq_pkg::MSG_CNT_W-1:0]   msg_cnt;

  // The input word being worked on.
  logic [mngq_pkg::NOTE_W-1:0]      cur_note;
  logic [mngq_pkg::VEL_W-1:0]       cur_vel;
  logic [mngq_pkg::TIME_W-1:0]      cur_now;

  mngq_pkg::cell_ctl_t              ctl;

  // Chain wiring; the element past the tail feeds zeros into the last cell.
  logic [mngq_pkg::NOTE_W-1:0]      note_arr  [0:QUEUE_DEPTH];
  logic [mngq_pkg::TIME_W-1:0]      start_arr [0:QUEUE_DEPTH];
  logic                             exp_arr   [0:QUEUE_DEPTH];
  logic                             shift_c   [0:QUEUE_DEPTH];

  logic                             accept;
  logic                             can_emit;
  logic                             emit;
  logic                             emit_kind;
  logic [mngq_pkg::NOTE_W-1:0]      emit_note;
  logic                             emit_last;
  logic                             do_remove;
  logic                             do_load;
  logic                             any_match;
  logic                             full;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == mngq_pkg::S_IDLE);
  assign can_emit = !out_valid || out_ready;
  assign full = (cnt == CW'(QUEUE_DEPTH));
  assign any_match = shift_c[QUEUE_DEPTH];

  assign ctl.remove = do_remove;
  assign ctl.at_head = (state != mngq_pkg::S_MATCH);
  assign ctl.new_note = cur_note;
  assign ctl.now = cur_now;
  assign ctl.gate = gate;

  assign note_arr[QUEUE_DEPTH] = '0;
  assign start_arr[QUEUE_DEPTH] = '0;
  assign exp_arr[QUEUE_DEPTH] = 1'b0;
  assign shift_c[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    mngq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .live      (CW'(i) < cnt),
      .head      (i == 0),
      .load_here (do_load && (cnt == CW'(i))),
      .shift_in  (shift_c[i]),
      .nbr_note  (note_arr[i+1]),
      .nbr_start (start_arr[i+1]),
      .note_q    (note_arr[i]),
      .start_q   (start_arr[i]),
      .expired   (exp_arr[i]),
      .shift_out (shift_c[i+1])
    );
  end

  // Sequencer: at most one output word per step; a step that sends a word waits
  // until the output register is free or being emptied.
  always_comb begin
    state_next = state;
    emit = 1'b0;
    emit_kind = mngq_pkg::KIND_OFF;
    emit_note = cur_note;
    emit_last = 1'b0;
    do_remove = 1'b0;
    do_load = 1'b0;
    case (state)
      mngq_pkg::S_IDLE: begin
        if (accept) begin
          if (command) begin
            state_next = mngq_pkg::S_EXPIRE;
          end else if (note[7]) begin
            state_next = mngq_pkg::S_IDLE;
          end else if (gate == '0) begin
            state_next = mngq_pkg::S_ZON;
          end else begin
            state_next = mngq_pkg::S_MATCH;
          end
        end
      end
      mngq_pkg::S_ZON: begin
        if (can_emit) begin
          emit = 1'b1;
          emit_kind = mngq_pkg::KIND_ON;
          state_next = mngq_pkg::S_ZOFF;
        end
      end
      mngq_pkg::S_ZOFF: begin
        if (can_emit) begin
          emit = 1'b1;
          emit_last = 1'b1;
          state_next = mngq_pkg::S_IDLE;
        end
      end
      mngq_pkg::S_MATCH: begin
        // A note that is already playing is ended before it restarts.
        if (!any_match) begin
          state_next = mngq_pkg::S_ON;
        end else if (can_emit) begin
          emit = 1'b1;
          do_remove = 1'b1;
          state_next = mngq_pkg::S_ON;
        end
      end
      mngq_pkg::S_ON: begin
        if (can_emit) begin
          emit = 1'b1;
          emit_kind = mngq_pkg::KIND_ON;
          emit_last = !full;
          state_next = full ? mngq_pkg::S_EVICT : mngq_pkg::S_APPEND;
        end
      end
      mngq_pkg::S_EVICT: begin
        if (can_emit) begin
          emit = 1'b1;
          emit_note = note_arr[0];
          emit_last = 1'b1;
          do_remove = 1'b1;
          state_next = mngq_pkg::S_APPEND;
        end
      end
      mngq_pkg::S_APPEND: begin
        do_load = 1'b1;
        state_next = mngq_pkg::S_IDLE;
      end
      mngq_pkg::S_EXPIRE: begin
        // The head is checked each step; the entry behind it and the message count
        // tell whether this note-off is the final word of the check.
        if (cnt == '0 || !exp_arr[0]) begin
          state_next = mngq_pkg::S_IDLE;
        end else if (can_emit) begin
          emit = 1'b1;
          emit_note = note_arr[0];
          emit_last = !((cnt > CW'(1)) && exp_arr[1] &&
                        (msg_cnt != mngq_pkg::MSG_CNT_W'(mngq_pkg::MAX_MSGS - 1)));
          do_remove = 1'b1;
          if (emit_last) begin
            state_next = mngq_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = mngq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mngq_pkg::S_IDLE;
      cnt <= '0;
      gate <= '0;
      msg_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        gate <= cfg_wdata;
      end
      if (do_remove) begin
        cnt <= cnt - CW'(1);
      end else if (do_load) begin
        cnt <= cnt + CW'(1);
      end
      if (accept) begin
        msg_cnt <= '0;
      end else if (emit) begin
        msg_cnt <= msg_cnt + mngq_pkg::MSG_CNT_W'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_note <= note[mngq_pkg::NOTE_W-1:0];
      cur_vel <= velocity;
      cur_now <= now_ms;
    end
    if (emit) begin
      message_kind <= emit_kind;
      out_note <= emit_note;
      out_velocity <= (emit_kind == mngq_pkg::KIND_ON) ? cur_vel : '0;
      last <= emit_last;
    end
  end

  // The list never holds more entries than it has cells.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  // Appending always leaves at least one playing note.
  a_append_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == mngq_pkg::S_APPEND) |=> (cnt != '0))
    else $error("list empty after append");

  // A note-off never carries a velocity.
  a_off_zero_vel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (message_kind == mngq_pkg::KIND_OFF)) |-> (out_velocity == '0))
    else $error("note-off with nonzero velocity");

  // An unassigned note is dropped without touching the list or the output.
  a_unassigned_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && !command && note[7]) |=> ((state == mngq_pkg::S_IDLE) && $stable(cnt)))
    else $error("unassigned note was not ignored");

  // Removal of a matching entry only happens when one was found.
  a_match_remove: assert property (@(posedge clk) disable iff (rst)
    ((state == mngq_pkg::S_MATCH) && do_remove) |-> any_match)
    else $error("removal without a matching entry");

endmodule
